[hdl/stepper_pulse_generator_with_ramp_assert.svh]
// Assertion macros for the stepper pulse generator.
// Included by the top level; holds nothing but macro definitions.
`ifndef STEPPER_PULSE_GENERATOR_WITH_RAMP_ASSERT_SVH
`define STEPPER_PULSE_GENERATOR_WITH_RAMP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SPGR_ASSERT_IMP(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
        else $error("same-cycle implication failed");
// Next-cycle implication
`define SPGR_ASSERT_NXT(lbl, clk_s, rst_s, pre, post) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
        else $error("next-cycle implication failed");
`else
`define SPGR_ASSERT_IMP(lbl, clk_s, rst_s, pre, post)
`define SPGR_ASSERT_NXT(lbl, clk_s, rst_s, pre, post)
`endif
`endif

[hdl/spgr_pkg.sv]
// Shared types and constants of the stepper pulse generator.
// No dependencies; used by spgr_ramp and the top level.
package spgr_pkg;

    // Field widths
    localparam int HP_BITS       = 20;
    localparam int RAMP_BITS     = 16;
    localparam int STEP_BITS     = 31;
    localparam int POS_OUT_BITS  = 32;
    localparam int CNT_BITS      = $clog2(HP_BITS);
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 88;
    localparam int FUNC_BITS     = 2;
    localparam int ADDR_BITS     = 4;
    localparam int APB_BITS      = 32;

    // Register reset values
    localparam logic [HP_BITS-1:0]   CRUISE_RST = 20'd250;
    localparam logic [HP_BITS-1:0]   START_RST  = 20'd2000;
    localparam logic [RAMP_BITS-1:0] RAMP_RST   = 16'd400;

    localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

    // Item functions
    localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_RESTART = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd2;

    // Register indexes (word address)
    localparam logic [1:0] REG_CRUISE = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_RAMP   = 2'd2;

    // Status of the ramp unit
    typedef struct packed {
        logic busy;
        logic done;
    } ramp_stat_t;

endpackage

[hdl/stepper_pulse_generator_with_ramp.sv]
// Stepper step-pulse generator with linear speed ramp; uses spgr_pkg and spgr_ramp.
// A result follows each input beat once the half period is recomputed: directly if cruise
// applies, else by load, bit-serial multiply (16 bits), bit-serial divide (20 bits), finish,
// plus any m_tready stall. One item at a time: no beat is accepted until its result is out;
// a register write blocks input for its recompute. rst_n clears control and generator state
// asynchronously; registers return to cruise 250, start 2000, ramp 400.
`include "stepper_pulse_generator_with_ramp_assert.svh"
module stepper_pulse_generator_with_ramp import spgr_pkg::*;
#(
    parameter int TIME_BITS     = 20,
    parameter int POSITION_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // [0] run, [1] direction_down, [33:2] position_value, [39:34] zero
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // [1:0] func
    input  logic [FUNC_BITS-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [0] step_level, [1] step_edge, [33:2] position, [64:34] steps_done,
    // [84:65] half_period_now, [87:85] zero
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [APB_BITS-1:0]      pwdata,
    output logic [APB_BITS-1:0]      prdata,
    output logic                     pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_HOLD = 3'b100
    } ctrl_state_t;

    localparam int CMP_BITS = (TIME_BITS > HP_BITS) ? TIME_BITS : HP_BITS;

    ctrl_state_t               state_reg, state_next;
    logic [HP_BITS-1:0]        cruise_reg, start_reg;
    logic [RAMP_BITS-1:0]      ramp_reg;
    logic                      level_reg, level_next;
    logic                      edge_reg, edge_next;
    logic [STEP_BITS-1:0]      steps_reg, steps_next;
    logic [POSITION_BITS-1:0]  position_reg, position_next;
    logic [TIME_BITS-1:0]      elapsed_reg, elapsed_next;
    logic [HP_BITS-1:0]        hp_reg, hp_next;
    logic                      go_reg;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0]  m_tdata_reg;

    logic                      cfg_wr;
    logic [1:0]                cfg_idx;
    logic                      in_accept;
    logic                      in_run;
    logic                      in_down;
    logic signed [31:0]        in_pos;
    logic [TIME_BITS-1:0]      elapsed_inc;
    logic                      hit;
    logic                      slot_free;
    logic                      out_load;
    logic [HP_BITS-1:0]        hp_out;
    logic [HP_BITS-1:0]        ramp_hp;
    ramp_stat_t                ramp_stat;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        case (cfg_idx)
            REG_CRUISE: prdata = APB_BITS'(cruise_reg);
            REG_START:  prdata = APB_BITS'(start_reg);
            REG_RAMP:   prdata = APB_BITS'(ramp_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cruise_reg <= CRUISE_RST;
            start_reg  <= START_RST;
            ramp_reg   <= RAMP_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_CRUISE: cruise_reg <= pwdata[HP_BITS-1:0];
                REG_START:  start_reg  <= pwdata[HP_BITS-1:0];
                REG_RAMP:   ramp_reg   <= pwdata[RAMP_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // Input beat fields
    assign in_run    = s_tdata[0];
    assign in_down   = s_tdata[1];
    assign in_pos    = s_tdata[33:2];
    assign s_tready  = (state_reg == S_IDLE) && !go_reg && !ramp_stat.busy;
    assign in_accept = s_tvalid && s_tready;

    // Tick timing against the half period in force
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign hit = in_run && (CMP_BITS'(elapsed_inc) >= CMP_BITS'(hp_reg));

    // Apply one item to the generator state
    always_comb
    begin
        level_next    = level_reg;
        edge_next     = edge_reg;
        steps_next    = steps_reg;
        position_next = position_reg;
        elapsed_next  = elapsed_reg;
        if (in_accept)
        begin
            edge_next = 1'b0;
            case (s_tuser)
                FUNC_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (hit)
                    begin
                        elapsed_next = '0;
                        level_next   = !level_reg;
                        if (!level_reg)
                        begin
                            edge_next = 1'b1;
                            if (steps_reg != STEP_MAX)
                            begin
                                steps_next = steps_reg + 1'b1;
                            end
                            position_next = in_down ? position_reg - 1'b1
                                                    : position_reg + 1'b1;
                        end
                    end
                end
                FUNC_RESTART:
                begin
                    steps_next = '0;
                end
                FUNC_LOAD:
                begin
                    position_next = POSITION_BITS'(in_pos);
                end
                default:
                begin
                    edge_next = 1'b0;
                end
            endcase
        end
    end

    // Recompute the half period after every item and register write
    spgr_ramp u_ramp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go_reg),
        .cruise      (cruise_reg),
        .start       (start_reg),
        .ramp_steps  (ramp_reg),
        .count       (steps_reg),
        .half_period (ramp_hp),
        .stat        (ramp_stat)
    );

    assign hp_next = ramp_stat.done ? ramp_hp : hp_reg;

    // Hand the result to the output register
    assign slot_free = !m_tvalid_reg || m_tready;
    assign out_load  = ((state_reg == S_CALC) && ramp_stat.done && slot_free)
                    || ((state_reg == S_HOLD) && slot_free);
    assign hp_out    = (state_reg == S_CALC) ? ramp_hp : hp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (ramp_stat.done)
                begin
                    state_next = slot_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            level_reg    <= 1'b0;
            edge_reg     <= 1'b0;
            steps_reg    <= '0;
            position_reg <= '0;
            elapsed_reg  <= '0;
            hp_reg       <= START_RST;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            edge_reg     <= edge_next;
            steps_reg    <= steps_next;
            position_reg <= position_next;
            elapsed_reg  <= elapsed_next;
            hp_reg       <= hp_next;
            go_reg       <= in_accept || cfg_wr;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= OUT_DATA_BITS'({hp_out, steps_reg,
                                           POS_OUT_BITS'(position_reg),
                                           edge_reg, level_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `SPGR_ASSERT_NXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SPGR_ASSERT_IMP(a_hp_range, clk, rst_n, ramp_stat.done && !go_reg && (cruise_reg < start_reg), (ramp_hp >= cruise_reg) && (ramp_hp <= start_reg))
    `SPGR_ASSERT_IMP(a_edge_high, clk, rst_n, m_tvalid && m_tdata[1], m_tdata[0])

endmodule

[hdl/spgr_ramp.sv]
// Ramp half-period unit: bit-serial multiply then bit-serial restoring divide.
// Depends on spgr_pkg.
module spgr_ramp import spgr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [HP_BITS-1:0]   cruise,
    input  logic [HP_BITS-1:0]   start,
    input  logic [RAMP_BITS-1:0] ramp_steps,
    input  logic [STEP_BITS-1:0] count,
    output logic [HP_BITS-1:0]   half_period,
    output ramp_stat_t           stat
);

    typedef enum logic [3:0] {
        R_IDLE = 4'b0001,
        R_MUL  = 4'b0010,
        R_DIV  = 4'b0100,
        R_FIN  = 4'b1000
    } ramp_state_t;

    localparam int PROD_BITS = HP_BITS + RAMP_BITS;

    ramp_state_t             state_reg, state_next;
    logic [CNT_BITS-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [HP_BITS-1:0]      diff_reg, diff_next;
    logic [HP_BITS-1:0]      st_reg, st_next;
    logic [HP_BITS-1:0]      hi_reg, hi_next;
    logic [RAMP_BITS-1:0]    lo_reg, lo_next;
    logic [RAMP_BITS-1:0]    rem_reg, rem_next;
    logic [HP_BITS-1:0]      num_reg, num_next;

    logic                    fast;
    logic [HP_BITS:0]        mac_sum;
    logic [PROD_BITS-1:0]    prod;
    logic [RAMP_BITS:0]      trial;
    logic [RAMP_BITS:0]      trial_diff;
    logic                    fits;

    // Cruise directly when not faster or when the ramp is over
    assign fast = (cruise >= start) || (count >= STEP_BITS'(ramp_steps));

    // One multiplier bit per cycle: add, then shift product right
    assign mac_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, diff_reg} : '0);
    assign prod    = {mac_sum, lo_reg[RAMP_BITS-1:1]};

    // One quotient bit per cycle
    assign trial      = {rem_reg, num_reg[HP_BITS-1]};
    assign fits       = trial >= {1'b0, ramp_steps};
    assign trial_diff = trial - {1'b0, ramp_steps};

    assign half_period = st_reg - num_reg;
    assign stat.busy   = state_reg != R_IDLE;
    assign stat.done   = state_reg == R_FIN;

    // Sequence multiply and divide
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        diff_next    = diff_reg;
        st_next      = st_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        rem_next     = rem_reg;
        num_next     = num_reg;
        if (go)
        begin
            if (fast)
            begin
                st_next    = cruise;
                num_next   = '0;
                state_next = R_FIN;
            end
            else
            begin
                diff_next    = start - cruise;
                st_next      = start;
                hi_next      = '0;
                lo_next      = count[RAMP_BITS-1:0];
                bit_cnt_next = CNT_BITS'(RAMP_BITS - 1);
                state_next   = R_MUL;
            end
        end
        else
        begin
            case (state_reg)
                R_MUL:
                begin
                    hi_next      = prod[PROD_BITS-1:RAMP_BITS];
                    lo_next      = prod[RAMP_BITS-1:0];
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == '0)
                    begin
                        // Top bits of the product already lie below the divisor
                        rem_next     = prod[PROD_BITS-1:HP_BITS];
                        num_next     = prod[HP_BITS-1:0];
                        bit_cnt_next = CNT_BITS'(HP_BITS - 1);
                        state_next   = R_DIV;
                    end
                end
                R_DIV:
                begin
                    rem_next     = fits ? trial_diff[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];
                    num_next     = {num_reg[HP_BITS-2:0], fits};
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (bit_cnt_reg == '0)
                    begin
                        state_next = R_FIN;
                    end
                end
                R_FIN:
                begin
                    state_next = R_IDLE;
                end
                R_IDLE:
                begin
                    state_next = R_IDLE;
                end
                default:
                begin
                    state_next = R_IDLE;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        bit_cnt_reg <= bit_cnt_next;
        diff_reg    <= diff_next;
        st_reg      <= st_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        rem_reg     <= rem_next;
        num_reg     <= num_next;
    end

endmodule
